// ----- rtl/core/agbd_pkg.sv -----
package agbd_pkg;

	localparam int ACC_WIDTH_DEF       = 24;
	localparam int COEFF_FRAC_BITS_DEF = 14;

	localparam int DIGIT_W     = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 17;

	localparam logic [CFG_INDEX_W-1:0] CFG_MARK_COEFF        = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPACE_COEFF       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_NOMINAL_STEP      = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_THRESHOLD = 2'd3;

	localparam logic [14:0] NOMINAL_STEP_RST      = 15'd8192;
	localparam logic [16:0] CARRIER_THRESHOLD_RST = 17'd1000;

	localparam logic [1:0] MAC_HOLD     = 2'd0;
	localparam logic [1:0] MAC_ADD_SQ   = 2'd1;
	localparam logic [1:0] MAC_SUB_PROD = 2'd2;

	typedef struct packed {
		logic       clr;
		logic [1:0] mode;
	} mac_ctl_t;

endpackage

// ----- rtl/core/agbd_mac.sv -----
module agbd_mac #(
	parameter int ACC_WIDTH       = agbd_pkg::ACC_WIDTH_DEF,
	parameter int COEFF_FRAC_BITS = agbd_pkg::COEFF_FRAC_BITS_DEF
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  agbd_pkg::mac_ctl_t                                     ctl,
	input  logic [$clog2((ACC_WIDTH+agbd_pkg::DIGIT_W-1)/agbd_pkg::DIGIT_W)-1:0] k,
	input  logic signed [ACC_WIDTH+agbd_pkg::DIGIT_W:0]            a,
	input  logic signed [agbd_pkg::DIGIT_W:0]                      b,
	output logic signed [ACC_WIDTH+2*agbd_pkg::DIGIT_W+1:0]        p,
	output logic signed [2*ACC_WIDTH+COEFF_FRAC_BITS+17:0]         acc
);

	localparam int DIG = agbd_pkg::DIGIT_W;
	localparam int ND  = (ACC_WIDTH + DIG - 1) / DIG;
	localparam int KW  = $clog2(ND);
	localparam int DSH = $clog2(DIG);
	localparam int PW  = ACC_WIDTH + 2*DIG + 2;
	localparam int EW  = 2*ACC_WIDTH + COEFF_FRAC_BITS + 18;

	logic [1:0]             mode_s1;
	logic [KW-1:0]          k_s1;
	logic signed [PW-1:0]   p_s1;
	logic signed [EW-1:0]   acc_q;
	logic signed [EW-1:0]   pe;

	assign pe  = EW'(p_s1);
	assign p   = p_s1;
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s1 <= agbd_pkg::MAC_HOLD;
		end else begin
			mode_s1 <= ctl.mode;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
		k_s1 <= k;
		if (ctl.clr) begin
			acc_q <= '0;
		end else begin
			unique case (mode_s1)
				agbd_pkg::MAC_ADD_SQ: begin
					acc_q <= acc_q + ((pe <<< COEFF_FRAC_BITS) <<< {k_s1, {DSH{1'b0}}});
				end
				agbd_pkg::MAC_SUB_PROD: begin
					acc_q <= acc_q - (pe <<< {k_s1, {DSH{1'b0}}});
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/afsk_goertzel_bit_demod_top.sv -----
// afsk_goertzel_bit_demod_top: 1-bit comparator samples in, one decided bit per bit period out.
// sample channel: sample_valid, sample_stall, sample_bit. a request is taken at an edge with
// valid high and stall low; stall stays high while the sample is being worked on.
// result channel: result_valid, result_stall, data_bit, carrier_present, mark_level,
// space_level, quality_pct. a result is held in an output register until taken.
// cfg channel: cfg_valid, cfg_ready (always high), cfg_index, cfg_data. index 0 mark coeff,
// 1 space coeff, 2 nominal step (also reloads the tracked step), 3 carrier threshold.
// write only while no sample is in flight and no result is pending.
// sequence: all products go through one shared multiplier. a sample inside a bit period takes
// one multiply and one update per tone. a sample that closes a bit period adds two energy
// passes with ND = ceil(ACC_WIDTH/16) digit products per square, then a decision step, a 7-step
// quality divide and an output step.
// the next sample is taken while a result waits; if the next result is ready first, the
// sequencer holds in its output state until the output register frees up.
// reset: coefficients 0, nominal step 8192, threshold 1000, recurrence state, bit phase,
// lock count and carrier flag cleared, no result pending.
module afsk_goertzel_bit_demod_top #(
	parameter int ACC_WIDTH       = agbd_pkg::ACC_WIDTH_DEF,
	parameter int COEFF_FRAC_BITS = agbd_pkg::COEFF_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [agbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [agbd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic                              sample_bit,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              data_bit,
	output logic                              carrier_present,
	output logic [15:0]                       mark_level,
	output logic [15:0]                       space_level,
	output logic [6:0]                        quality_pct
);

	localparam int DIG = agbd_pkg::DIGIT_W;
	localparam int ND  = (ACC_WIDTH + DIG - 1) / DIG;
	localparam int KW  = $clog2(ND);
	localparam int DSH = $clog2(DIG);
	localparam int DWX = ND * DIG;
	localparam int MAW = ACC_WIDTH + DIG + 1;
	localparam int PW  = ACC_WIDTH + 2*DIG + 2;
	localparam int EW  = 2*ACC_WIDTH + COEFF_FRAC_BITS + 18;
	localparam int GW  = ACC_WIDTH + 18;
	localparam int LVL = 3 * COEFF_FRAC_BITS;

	localparam logic [KW-1:0]        K_LAST = KW'(ND - 1);
	localparam logic signed [GW-1:0] QMAX   = (GW'(1) <<< (ACC_WIDTH - 1)) - GW'(1);
	localparam logic signed [GW-1:0] QMIN   = ~QMAX;
	localparam logic signed [GW-1:0] XP     = GW'(1) <<< COEFF_FRAC_BITS;

	localparam logic [7:0]  LOCK_MAX   = 8'd255;
	localparam logic [7:0]  LOCK_ON    = 8'd5;
	localparam logic [15:0] STEP_RANGE = 16'd100;
	localparam logic [2:0]  DIV_STEPS  = 3'd6;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_GMUL  = 4'd1;
	localparam logic [3:0] ST_GUPD  = 4'd2;
	localparam logic [3:0] ST_ECQ   = 4'd3;
	localparam logic [3:0] ST_ESQ1  = 4'd4;
	localparam logic [3:0] ST_ESQ2  = 4'd5;
	localparam logic [3:0] ST_ECR   = 4'd6;
	localparam logic [3:0] ST_EWAIT = 4'd7;
	localparam logic [3:0] ST_EDONE = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;
	localparam logic [3:0] ST_DIV   = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0]               state_q;
	logic                     tone_q;
	logic [KW-1:0]            k_q;
	logic                     wrap_q;
	logic                     bit_q;
	logic signed [15:0]       mark_c_q;
	logic signed [15:0]       space_c_q;
	logic [14:0]              nominal_q;
	logic [16:0]              thr_q;
	logic [15:0]              step_q;
	logic [15:0]              bit_phase_q;
	logic                     prev_bit_q;
	logic                     carrier_q;
	logic [7:0]               lock_q;
	logic signed [ACC_WIDTH-1:0] mark_a_q;
	logic signed [ACC_WIDTH-1:0] mark_b_q;
	logic signed [ACC_WIDTH-1:0] space_a_q;
	logic signed [ACC_WIDTH-1:0] space_b_q;
	logic signed [MAW-1:0]    cq_q;
	logic signed [EW-1:0]     em_q;
	logic [15:0]              ml_q;
	logic [15:0]              sl_q;
	logic [22:0]              num_q;
	logic [17:0]              den_q;
	logic [6:0]               quo_q;
	logic [2:0]               div_i_q;
	logic                     result_valid_q;
	logic                     data_bit_q;
	logic                     carrier_present_q;
	logic [15:0]              mark_level_q;
	logic [15:0]              space_level_q;
	logic [6:0]               quality_pct_q;

	logic signed [ACC_WIDTH-1:0] q1_sel;
	logic signed [ACC_WIDTH-1:0] q2_sel;
	logic signed [15:0]          c_sel;
	logic signed [ACC_WIDTH-1:0] dsrc;
	logic [DWX-1:0]              dext;
	logic [DIG-1:0]              dsel;
	logic signed [DIG:0]         dig_b;
	agbd_pkg::mac_ctl_t          mac_ctl;
	logic signed [MAW-1:0]       mac_a;
	logic signed [DIG:0]         mac_b;
	logic signed [PW-1:0]        mac_p;
	logic signed [EW-1:0]        mac_acc;
	logic signed [PW-1:0]        p_sh;
	logic signed [GW-1:0]        g_sum;
	logic signed [ACC_WIDTH-1:0] q0;
	logic [16:0]                 sum17;
	logic                        nb_c;
	logic [15:0]                 ml_c;
	logic [15:0]                 sl_c;
	logic [16:0]                 total_c;
	logic [15:0]                 diff_c;
	logic [22:0]                 diff_x;
	logic [22:0]                 num_c;
	logic signed [17:0]          st_c;
	logic signed [17:0]          lo_c;
	logic signed [17:0]          hi_c;
	logic [15:0]                 step_nx;
	logic [7:0]                  lock_nx;
	logic                        flag_nx;
	logic [24:0]                 trial_c;
	logic                        ge_c;
	logic                        out_load;

	function automatic logic [15:0] level_of(input logic signed [EW-1:0] e);
		logic [15:0] r;
		if (e < 0) begin
			r = '0;
		end else if (|e[EW-1:LVL+16]) begin
			r = '1;
		end else begin
			r = e[LVL+15:LVL];
		end
		return r;
	endfunction

	assign cfg_ready       = 1'b1;
	assign sample_stall    = (state_q != ST_IDLE);
	assign result_valid    = result_valid_q;
	assign data_bit        = data_bit_q;
	assign carrier_present = carrier_present_q;
	assign mark_level      = mark_level_q;
	assign space_level     = space_level_q;
	assign quality_pct     = quality_pct_q;

	assign q1_sel = tone_q ? space_a_q : mark_a_q;
	assign q2_sel = tone_q ? space_b_q : mark_b_q;
	assign c_sel  = tone_q ? space_c_q : mark_c_q;

	assign sum17    = {1'b0, bit_phase_q} + {1'b0, step_q};
	assign out_load = (state_q == ST_OUT) && (!result_valid_q || !result_stall);

	// operand selection for the shared multiplier
	always_comb begin
		mac_ctl.clr  = 1'b0;
		mac_ctl.mode = agbd_pkg::MAC_HOLD;
		mac_a        = MAW'(q1_sel);
		dsrc         = q1_sel;
		unique case (state_q)
			ST_ECQ: begin
				mac_ctl.clr = 1'b1;
			end
			ST_ESQ1: begin
				mac_ctl.mode = agbd_pkg::MAC_ADD_SQ;
			end
			ST_ESQ2: begin
				mac_ctl.mode = agbd_pkg::MAC_ADD_SQ;
				mac_a        = MAW'(q2_sel);
				dsrc         = q2_sel;
			end
			ST_ECR: begin
				mac_ctl.mode = agbd_pkg::MAC_SUB_PROD;
				mac_a        = cq_q;
				dsrc         = q2_sel;
			end
			default: begin
				mac_ctl.mode = agbd_pkg::MAC_HOLD;
			end
		endcase
		dext  = DWX'(dsrc);
		dsel  = dext[{k_q, {DSH{1'b0}}} +: DIG];
		dig_b = (k_q == K_LAST) ? $signed({dsel[DIG-1], dsel}) : $signed({1'b0, dsel});
		if (state_q == ST_ESQ1 || state_q == ST_ESQ2 || state_q == ST_ECR) begin
			mac_b = dig_b;
		end else begin
			mac_b = (DIG+1)'(c_sel);
		end
	end

	agbd_mac #(
		.ACC_WIDTH       (ACC_WIDTH),
		.COEFF_FRAC_BITS (COEFF_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.k      (k_q),
		.a      (mac_a),
		.b      (mac_b),
		.p      (mac_p),
		.acc    (mac_acc)
	);

	// recurrence update
	always_comb begin
		p_sh  = mac_p >>> COEFF_FRAC_BITS;
		g_sum = $signed(p_sh[GW-1:0]) - GW'(q2_sel) + (bit_q ? XP : -XP);
		if (g_sum > QMAX) begin
			q0 = QMAX[ACC_WIDTH-1:0];
		end else if (g_sum < QMIN) begin
			q0 = QMIN[ACC_WIDTH-1:0];
		end else begin
			q0 = g_sum[ACC_WIDTH-1:0];
		end
	end

	// decision, step tracking, lock counter
	always_comb begin
		nb_c    = (em_q > mac_acc);
		ml_c    = level_of(em_q);
		sl_c    = level_of(mac_acc);
		total_c = {1'b0, ml_c} + {1'b0, sl_c};
		diff_c  = (ml_c > sl_c) ? (ml_c - sl_c) : (sl_c - ml_c);
		diff_x  = {7'd0, diff_c};
		num_c   = (diff_x << 6) + (diff_x << 5) + (diff_x << 2);

		st_c = $signed({2'b00, step_q}) + (bit_phase_q[15] ? 18'sd1 : -18'sd1);
		lo_c = $signed({3'b000, nominal_q}) - $signed({2'b00, STEP_RANGE});
		hi_c = $signed({3'b000, nominal_q}) + $signed({2'b00, STEP_RANGE});
		if (lo_c < 0) begin
			lo_c = '0;
		end
		if (st_c < lo_c) begin
			st_c = lo_c;
		end else if (st_c > hi_c) begin
			st_c = hi_c;
		end
		step_nx = st_c[15:0];

		if (total_c > thr_q) begin
			lock_nx = (lock_q != LOCK_MAX) ? lock_q + 8'd1 : lock_q;
			flag_nx = (lock_nx > LOCK_ON) ? 1'b1 : carrier_q;
		end else begin
			lock_nx = (lock_q != 8'd0) ? lock_q - 8'd1 : lock_q;
			flag_nx = (lock_nx == 8'd0) ? 1'b0 : carrier_q;
		end

		trial_c = {7'd0, den_q} << div_i_q;
		ge_c    = ({2'b00, num_q} >= trial_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tone_q         <= 1'b0;
			k_q            <= '0;
			wrap_q         <= 1'b0;
			mark_c_q       <= '0;
			space_c_q      <= '0;
			nominal_q      <= agbd_pkg::NOMINAL_STEP_RST;
			thr_q          <= agbd_pkg::CARRIER_THRESHOLD_RST;
			step_q         <= {1'b0, agbd_pkg::NOMINAL_STEP_RST};
			bit_phase_q    <= '0;
			prev_bit_q     <= 1'b0;
			carrier_q      <= 1'b0;
			lock_q         <= '0;
			mark_a_q       <= '0;
			mark_b_q       <= '0;
			space_a_q      <= '0;
			space_b_q      <= '0;
			div_i_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						bit_phase_q <= sum17[15:0];
						wrap_q      <= sum17[16];
						tone_q      <= 1'b0;
						state_q     <= ST_GMUL;
					end
				end
				ST_GMUL: begin
					state_q <= ST_GUPD;
				end
				ST_GUPD: begin
					if (tone_q) begin
						space_b_q <= space_a_q;
						space_a_q <= q0;
					end else begin
						mark_b_q <= mark_a_q;
						mark_a_q <= q0;
					end
					if (!tone_q) begin
						tone_q  <= 1'b1;
						state_q <= ST_GMUL;
					end else if (wrap_q) begin
						tone_q  <= 1'b0;
						state_q <= ST_ECQ;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ECQ: begin
					k_q     <= '0;
					state_q <= ST_ESQ1;
				end
				ST_ESQ1: begin
					if (k_q == K_LAST) begin
						k_q     <= '0;
						state_q <= ST_ESQ2;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_ESQ2: begin
					if (k_q == K_LAST) begin
						k_q     <= '0;
						state_q <= ST_ECR;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_ECR: begin
					if (k_q == K_LAST) begin
						k_q     <= '0;
						state_q <= ST_EWAIT;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_EWAIT: begin
					state_q <= ST_EDONE;
				end
				ST_EDONE: begin
					if (!tone_q) begin
						tone_q  <= 1'b1;
						state_q <= ST_ECQ;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (nb_c != prev_bit_q) begin
						step_q <= step_nx;
					end
					prev_bit_q <= nb_c;
					lock_q     <= lock_nx;
					carrier_q  <= flag_nx;
					mark_a_q   <= '0;
					mark_b_q   <= '0;
					space_a_q  <= '0;
					space_b_q  <= '0;
					div_i_q    <= DIV_STEPS;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					if (div_i_q == 3'd0) begin
						state_q <= ST_OUT;
					end else begin
						div_i_q <= div_i_q - 3'd1;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					agbd_pkg::CFG_MARK_COEFF: begin
						mark_c_q <= cfg_data[15:0];
					end
					agbd_pkg::CFG_SPACE_COEFF: begin
						space_c_q <= cfg_data[15:0];
					end
					agbd_pkg::CFG_NOMINAL_STEP: begin
						nominal_q <= cfg_data[14:0];
						step_q    <= {1'b0, cfg_data[14:0]};
					end
					agbd_pkg::CFG_CARRIER_THRESHOLD: begin
						thr_q <= cfg_data[16:0];
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample_valid) begin
			bit_q <= sample_bit;
		end
		if (state_q == ST_ESQ1 && k_q == '0) begin
			cq_q <= mac_p[MAW-1:0];
		end
		if (state_q == ST_EDONE && !tone_q) begin
			em_q <= mac_acc;
		end
		if (state_q == ST_FIN) begin
			ml_q  <= ml_c;
			sl_q  <= sl_c;
			num_q <= num_c;
			den_q <= {1'b0, total_c} + 18'd1;
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (ge_c) begin
				num_q <= num_q - trial_c[22:0];
			end
			quo_q <= {quo_q[5:0], ge_c};
		end
		if (out_load) begin
			data_bit_q        <= prev_bit_q;
			carrier_present_q <= carrier_q;
			mark_level_q      <= ml_q;
			space_level_q     <= sl_q;
			quality_pct_q     <= quo_q;
		end
	end

`ifndef SYNTHESIS
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ({1'b0, nominal_q} + STEP_RANGE))
		else $error("tracked step above nominal plus range");

	a_flag_needs_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(lock_q == 8'd0) |-> !carrier_q)
		else $error("carrier flag set with zero lock count");

	a_quality_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (quo_q < 7'd100))
		else $error("quality quotient out of range");

	a_fin_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> wrap_q)
		else $error("decision without bit boundary");
`endif

endmodule
